@@ rtl/ffa_pkg.sv @@
// Shared types, codes and the partition capacity table for the allocator.
package ffa_pkg;

	localparam int MAX_PARTS          = 16;
	localparam int DEF_NUM_PARTITIONS = 10;
	localparam int DEF_ID_WIDTH       = 16;

	localparam logic [1:0] OP_ALLOC  = 2'd0;
	localparam logic [1:0] OP_FREE   = 2'd1;
	localparam logic [1:0] OP_LOOKUP = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_NONE    = 2'd2;

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] owner_id;
		logic [15:0] request_size;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] partition_index;
		logic [7:0] owned_size;
	} rsp_t;

	// Table update produced by one request; the selected entry travels beside it.
	typedef struct packed {
		logic alloc;
		logic rel;
	} upd_t;

	function automatic logic [7:0] part_capacity(input logic [3:0] idx);
		logic [7:0] cap;
		case (idx)
			4'd0, 4'd1: cap = 8'd2;
			4'd2, 4'd3: cap = 8'd4;
			4'd4, 4'd5: cap = 8'd16;
			4'd6, 4'd7: cap = 8'd32;
			4'd8:       cap = 8'd64;
			default:    cap = 8'd128;
		endcase
		return cap;
	endfunction

endpackage

@@ rtl/ffa_pick.sv @@
// Request decode, first-fit and owner search with priority pick over the partition table.
module ffa_pick #(
	parameter int NUM_PARTITIONS = ffa_pkg::DEF_NUM_PARTITIONS,
	parameter int ID_WIDTH = ffa_pkg::DEF_ID_WIDTH,
	localparam int IdW = (ID_WIDTH < 16) ? ID_WIDTH : 16
) (
	input  ffa_pkg::req_t          req,
	input  logic [NUM_PARTITIONS-1:0] part_free,
	input  logic [IdW-1:0]         part_owner [NUM_PARTITIONS],
	input  logic [7:0]             part_size [NUM_PARTITIONS],
	output ffa_pkg::rsp_t          rsp,
	output ffa_pkg::upd_t          upd,
	output logic [NUM_PARTITIONS-1:0] sel
);
	import ffa_pkg::*;

	logic [IdW-1:0]            id;
	logic                      arg_ok;
	logic                      is_alloc;
	logic                      is_lookup;
	logic [NUM_PARTITIONS-1:0] cand;
	logic [3:0]                pick;
	logic [7:0]                pick_size;

	assign id        = req.owner_id[IdW-1:0];
	assign is_alloc  = (req.operation == OP_ALLOC);
	assign is_lookup = (req.operation == OP_LOOKUP);

	always_comb begin
		case (req.operation)
			OP_ALLOC:            arg_ok = (id != '0) && (req.request_size != 16'd0);
			OP_FREE, OP_LOOKUP:  arg_ok = (id != '0);
			default:             arg_ok = 1'b0;
		endcase
	end

	always_comb begin
		for (int i = 0; i < NUM_PARTITIONS; i++) begin
			if (is_alloc)
				cand[i] = part_free[i] &&
					({8'd0, part_capacity(4'(i))} >= req.request_size);
			else
				cand[i] = !part_free[i] && (part_owner[i] == id);
		end
	end

	// Lowest-numbered candidate wins: scan down so the last hit stands.
	always_comb begin
		pick = 4'd0;
		for (int i = NUM_PARTITIONS - 1; i >= 0; i--) begin
			if (cand[i])
				pick = 4'(i);
		end
	end

	always_comb begin
		sel       = '0;
		pick_size = 8'd0;
		for (int i = 0; i < NUM_PARTITIONS; i++) begin
			if (pick == 4'(i)) begin
				sel[i]    = arg_ok && (cand != '0);
				pick_size = part_size[i];
			end
		end
	end

	always_comb begin
		rsp = '0;
		upd = '0;
		if (!arg_ok) begin
			rsp.status = ST_INVALID;
		end else if (cand == '0) begin
			rsp.status = ST_NONE;
		end else begin
			rsp.status          = ST_OK;
			rsp.partition_index = pick;
			rsp.owned_size      = is_lookup ? pick_size : 8'd0;
			upd.alloc           = is_alloc;
			upd.rel             = (req.operation == OP_FREE);
		end
	end

endmodule

@@ rtl/fixed_partition_first_fit_allocator.sv @@
// Top level of the first-fit fixed-partition allocator.
//
//   channel   dir   handshake            payload
//   req       in    req_valid/req_stall  ffa_pkg::req_t (operation, owner_id, request_size)
//   rsp       out   rsp_valid/rsp_stall  ffa_pkg::rsp_t (status, partition_index, owned_size)
//
// One request per cycle unless rsp stalls: input register, then one pass of parallel
// compare and priority pick over the partition table into the response register.
// Each request passes from the input register to the response register; the table
// is written as it leaves the input register, so the next request sees the update.
// Stall on rsp holds the response register; req_stall rises only while a held
// request waits behind a stalled response.
// Reset marks every partition free and empties both registers.
module fixed_partition_first_fit_allocator #(
	parameter int NUM_PARTITIONS = ffa_pkg::DEF_NUM_PARTITIONS,
	parameter int ID_WIDTH = ffa_pkg::DEF_ID_WIDTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  ffa_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output ffa_pkg::rsp_t rsp
);
	import ffa_pkg::*;

	localparam int IdW = (ID_WIDTH < 16) ? ID_WIDTH : 16;

	logic                      valid_s1;
	req_t                      req_s1;
	logic                      out_free;
	logic                      move;

	logic [NUM_PARTITIONS-1:0] part_free_q;
	logic [IdW-1:0]            part_owner_q [NUM_PARTITIONS];
	logic [7:0]                part_size_q [NUM_PARTITIONS];

	rsp_t                      rsp_next;
	upd_t                      upd;
	logic [NUM_PARTITIONS-1:0] sel;

	logic                      rsp_valid_q;
	rsp_t                      rsp_q;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign move      = valid_s1 && out_free;
	assign req_stall = valid_s1 && !out_free;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall)
			req_s1 <= req;
	end

	ffa_pick #(
		.NUM_PARTITIONS(NUM_PARTITIONS),
		.ID_WIDTH(ID_WIDTH)
	) u_pick (
		.req(req_s1),
		.part_free(part_free_q),
		.part_owner(part_owner_q),
		.part_size(part_size_q),
		.rsp(rsp_next),
		.upd(upd),
		.sel(sel)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_free_q <= '1;
			for (int i = 0; i < NUM_PARTITIONS; i++) begin
				part_owner_q[i] <= '0;
				part_size_q[i]  <= 8'd0;
			end
		end else if (move) begin
			for (int i = 0; i < NUM_PARTITIONS; i++) begin
				if (sel[i] && upd.alloc) begin
					part_free_q[i]  <= 1'b0;
					part_owner_q[i] <= req_s1.owner_id[IdW-1:0];
					part_size_q[i]  <= req_s1.request_size[7:0];
				end else if (sel[i] && upd.rel) begin
					part_free_q[i]  <= 1'b1;
					part_owner_q[i] <= '0;
					part_size_q[i]  <= 8'd0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move)
			rsp_q <= rsp_next;
	end

endmodule

@@ rtl/ffa_check.sv @@
// Port-level checks for the allocator and the bind that attaches them.
module ffa_check (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input ffa_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input ffa_pkg::rsp_t rsp
);
	import ffa_pkg::*;

	// Hold a stalled response transaction.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	// Backpressure on requests only comes from a stalled response.
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid && rsp_stall)
		else $error("request stalled without response backpressure");

	// A failed request reports neither an index nor a size.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != ST_OK) |->
			(rsp.partition_index == 4'd0) && (rsp.owned_size == 8'd0))
		else $error("failed response carries index or size");

	// Status codes stay within ok, invalid and not found.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.status == ST_OK) || (rsp.status == ST_INVALID) ||
			(rsp.status == ST_NONE))
		else $error("undefined status code");

endmodule

bind fixed_partition_first_fit_allocator ffa_check u_ffa_check (.*);

@@ tb/tb_fixed_partition_first_fit_allocator.sv @@
// Testbench for the first-fit fixed-partition allocator: random and directed requests.
`timescale 1ns / 100ps

module tb_fixed_partition_first_fit_allocator;
	import ffa_pkg::*;

	localparam int N_PARTS     = DEF_NUM_PARTITIONS;
	localparam int N_RANDOM    = 2000;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_AT     = 1000;
	localparam int HOLD_LEN    = 300;
	localparam int QUIET_FROM  = 2000;
	localparam int QUIET_TO    = 2600;
	localparam int DRAIN_WAIT  = 10;

	localparam logic [1:0] OP_RESERVED = 2'd3;

	localparam logic [7:0] PART_CAP [N_PARTS] = '{
		8'd2, 8'd2, 8'd4, 8'd4, 8'd16, 8'd16, 8'd32, 8'd32, 8'd64, 8'd128
	};

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  req_valid = 1'b0;
	logic  req_stall;
	req_t  req = '0;
	logic  rsp_valid;
	logic  rsp_stall = 1'b0;
	rsp_t  rsp;

	// Predicted partition table
	logic        slot_free [N_PARTS];
	logic [15:0] slot_owner [N_PARTS];
	logic [7:0]  slot_size [N_PARTS];

	req_t pending_reqs [$];
	rsp_t expected_rsps [$];
	int   cycle_count = 0;
	int   hold_left = 0;
	int   n_errors = 0;
	logic [15:0] id_pool [8];

	fixed_partition_first_fit_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Count down the long receiver hold-off
	always @(posedge clk) begin
		if (cycle_count == HOLD_AT)
			hold_left <= HOLD_LEN;
		else if (hold_left > 0)
			hold_left <= hold_left - 1;
	end

	function automatic bit quiet_phase();
		return cycle_count >= QUIET_FROM && cycle_count < QUIET_TO;
	endfunction

	function automatic bit idle_roll();
		return !quiet_phase() && ($urandom_range(0, 99) < 35);
	endfunction

	// Apply one request to the predicted table and return its response.
	function automatic rsp_t apply_request(req_t r);
		rsp_t o;
		int   hit;
		o.status = ST_INVALID;
		o.partition_index = '0;
		o.owned_size = '0;
		hit = -1;
		case (r.operation)
			OP_ALLOC: begin
				if (r.request_size != 0 && r.owner_id != 0) begin
					o.status = ST_NONE;
					for (int i = 0; i < N_PARTS; i++)
						if (hit < 0 && slot_free[i] && PART_CAP[i] >= r.request_size)
							hit = i;
					if (hit >= 0) begin
						slot_free[hit] = 1'b0;
						slot_owner[hit] = r.owner_id;
						slot_size[hit] = r.request_size[7:0];
						o.status = ST_OK;
						o.partition_index = hit[3:0];
					end
				end
			end
			OP_FREE, OP_LOOKUP: begin
				if (r.owner_id != 0) begin
					for (int i = 0; i < N_PARTS; i++)
						if (hit < 0 && !slot_free[i] && slot_owner[i] == r.owner_id)
							hit = i;
					if (hit < 0) begin
						o.status = ST_NONE;
					end else begin
						o.status = ST_OK;
						o.partition_index = hit[3:0];
						if (r.operation == OP_FREE) begin
							slot_free[hit] = 1'b1;
							slot_owner[hit] = '0;
							slot_size[hit] = '0;
						end else begin
							o.owned_size = slot_size[hit];
						end
					end
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	task automatic queue_req(input logic [1:0] op, input logic [15:0] id,
			input logic [15:0] size);
		req_t r;
		r.operation = op;
		r.owner_id = id;
		r.request_size = size;
		pending_reqs.push_back(r);
	endtask

	function automatic logic [15:0] pick_size();
		int sel;
		sel = $urandom_range(0, 19);
		case (sel)
			0, 1, 2: return 16'($urandom_range(1, 2));
			3, 4, 5: return 16'($urandom_range(1, 4));
			6, 7, 8: return 16'($urandom_range(1, 16));
			9, 10, 11: return 16'($urandom_range(1, 32));
			12, 13, 14: return 16'($urandom_range(1, 64));
			15, 16, 17: return 16'($urandom_range(1, 128));
			18: return 16'($urandom_range(129, 65535));
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// Driver: offer the next request, hold it while stalled
	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && !req_stall)
				expected_rsps.push_back(apply_request(req));
			if (!req_valid || !req_stall) begin
				if (pending_reqs.size() > 0 && !idle_roll()) begin
					req <= pending_reqs.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each response transaction and drive the stall
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsps.size() == 0) begin
					$error("unexpected response transaction: status %0d index %0d size %0d",
						rsp.status, rsp.partition_index, rsp.owned_size);
					n_errors++;
				end else begin
					want = expected_rsps.pop_front();
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, rsp.status);
						n_errors++;
					end
					if (rsp.partition_index !== want.partition_index) begin
						$error("partition_index: expected %0d, actual %0d",
							want.partition_index, rsp.partition_index);
						n_errors++;
					end
					if (rsp.owned_size !== want.owned_size) begin
						$error("owned_size: expected %0d, actual %0d",
							want.owned_size, rsp.owned_size);
						n_errors++;
					end
				end
			end
			if (hold_left > 0)
				rsp_stall <= 1'b1;
			else
				rsp_stall <= idle_roll();
		end
	end

	initial begin
		int sel;
		logic [15:0] id;
		for (int i = 0; i < N_PARTS; i++) begin
			slot_free[i] = 1'b1;
			slot_owner[i] = '0;
			slot_size[i] = '0;
		end
		for (int i = 0; i < 5; i++)
			id_pool[i] = 16'(i + 1);
		for (int i = 5; i < 8; i++)
			id_pool[i] = 16'($urandom_range(1, 65535));

		// Directed: empty table, rejects, fits at several capacities, duplicate ids
		queue_req(OP_LOOKUP, 16'd1, 16'd0);
		queue_req(OP_FREE, 16'd1, 16'd0);
		queue_req(OP_ALLOC, 16'd0, 16'd5);
		queue_req(OP_ALLOC, 16'd1, 16'd0);
		queue_req(OP_RESERVED, 16'hFFFF, 16'hFFFF);
		queue_req(OP_ALLOC, 16'hFFFF, 16'd129);
		queue_req(OP_ALLOC, 16'hFFFF, 16'hFFFF);
		queue_req(OP_ALLOC, 16'd1, 16'd1);
		queue_req(OP_ALLOC, 16'd2, 16'd2);
		queue_req(OP_ALLOC, 16'd3, 16'd3);
		queue_req(OP_ALLOC, 16'd4, 16'd17);
		queue_req(OP_ALLOC, 16'd5, 16'd128);
		queue_req(OP_ALLOC, 16'd6, 16'd128);
		queue_req(OP_ALLOC, 16'hFFFF, 16'd2);
		queue_req(OP_ALLOC, 16'hFFFF, 16'd64);
		queue_req(OP_LOOKUP, 16'hFFFF, 16'hFFFF);
		queue_req(OP_FREE, 16'hFFFF, 16'd0);
		queue_req(OP_LOOKUP, 16'hFFFF, 16'd0);
		queue_req(OP_LOOKUP, 16'd0, 16'd0);
		queue_req(OP_FREE, 16'd0, 16'd0);
		queue_req(OP_LOOKUP, 16'd5, 16'd0);
		queue_req(OP_FREE, 16'd5, 16'd0);
		queue_req(OP_ALLOC, 16'h8000, 16'h0080);
		queue_req(OP_RESERVED, 16'd0, 16'd0);

		// Random: mostly well-formed traffic on a small id pool, some noise
		for (int n = 0; n < N_RANDOM; n++) begin
			sel = $urandom_range(0, 99);
			id = id_pool[$urandom_range(0, 7)];
			if (sel < 40)
				queue_req(OP_ALLOC, id, pick_size());
			else if (sel < 70)
				queue_req(OP_FREE, id, 16'($urandom_range(0, 65535)));
			else if (sel < 90)
				queue_req(OP_LOOKUP, id, 16'($urandom_range(0, 65535)));
			else if (sel < 93)
				queue_req(2'($urandom_range(0, 3)), 16'd0, pick_size());
			else if (sel < 95)
				queue_req(OP_ALLOC, id, 16'd0);
			else if (sel < 97)
				queue_req(OP_RESERVED, 16'($urandom_range(0, 65535)),
					16'($urandom_range(0, 65535)));
			else
				queue_req(2'($urandom_range(0, 2)), 16'($urandom_range(0, 65535)),
					16'($urandom_range(0, 65535)));
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Sample on the falling edge, away from the driving edge
		@(negedge clk);
		while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
		if (n_errors == 0 && expected_rsps.size() == 0)
			$display("[fixed_partition_first_fit_allocator] OK");
		else
			$display("[fixed_partition_first_fit_allocator] ERROR");
		$finish;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("[fixed_partition_first_fit_allocator] ERROR");
		$finish;
	end

endmodule
